>>> design/ilwc_pkg.sv
package ilwc_pkg;

    // Length thresholds and the saturation point of both counters
    localparam int INT_MAX_DIGITS        = 10;
    localparam int LL_MAX_DIGITS         = 19;
    localparam int ULL_MAX_DIGITS        = 20;
    localparam int COUNT_CAP             = 21;
    localparam int CNT_W                 = 5;
    localparam int NUM_BOUNDS            = 5;
    localparam int BOUND_MAX_LEN         = 20;

    // Bound string selectors
    localparam logic [2:0] B_INT_POS = 3'd0;
    localparam logic [2:0] B_INT_NEG = 3'd1;
    localparam logic [2:0] B_LL_POS  = 3'd2;
    localparam logic [2:0] B_LL_NEG  = 3'd3;
    localparam logic [2:0] B_ULL     = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        CLS_INT   = 2'd0,
        CLS_LONG  = 2'd1,
        CLS_ULONG = 2'd2,
        CLS_DEC   = 2'd3
    } t_class;

    // Running compare against one bound: equal so far, below or above
    typedef enum logic [1:0] {
        CMP_UND  = 2'd0,
        CMP_LESS = 2'd1,
        CMP_MORE = 2'd2
    } t_cmp;

    // Literal state after the current character has been taken in
    typedef struct packed {
        logic                        neg;
        logic [CNT_W-1:0]            raw_len;
        logic [CNT_W-1:0]            sig_cnt;
        t_cmp [NUM_BOUNDS-1:0]       status;
    } t_scan_state;

    // Bound strings, right aligned, first character in the highest used byte
    localparam logic [NUM_BOUNDS-1:0][BOUND_MAX_LEN*8-1:0] BOUND_TEXT = '{
        (BOUND_MAX_LEN*8)'("18446744073709551615"),
        (BOUND_MAX_LEN*8)'("9223372036854775808"),
        (BOUND_MAX_LEN*8)'("9223372036854775807"),
        (BOUND_MAX_LEN*8)'("2147483648"),
        (BOUND_MAX_LEN*8)'("2147483647")
    };

    localparam logic [NUM_BOUNDS-1:0][CNT_W-1:0] BOUND_LEN = '{
        5'd20, 5'd19, 5'd19, 5'd10, 5'd10
    };

    // Saturating count step
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_W'(COUNT_CAP)) ? v + 1'b1 : CNT_W'(COUNT_CAP);
    endfunction

    // Character of bound b at significant position pos, zero past its end
    function automatic logic [7:0] bound_char(input logic [2:0] b,
                                              input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] idx;
        idx = BOUND_LEN[b] - 1'b1 - pos;
        if (pos >= BOUND_LEN[b]) begin
            return 8'd0;
        end
        return BOUND_TEXT[b][{idx, 3'b000} +: 8];
    endfunction

endpackage

>>> design/ilwc_scan.sv
module ilwc_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    output ilwc_pkg::t_scan_state o_view
);

    logic                                    r_first;
    logic                                    r_lead_zero;
    ilwc_pkg::t_scan_state                   r_st;

    logic                                    n_first;
    logic                                    n_lead_zero;
    ilwc_pkg::t_scan_state                   n_st;

    logic                                    is_sign;
    logic                                    is_lead_zero;
    logic                                    is_sig;
    logic [7:0]                              ref_ch;

    // Update the literal state with the held character
    always_comb begin
        is_sign      = r_first && (i_char == ilwc_pkg::CH_PLUS ||
                                   i_char == ilwc_pkg::CH_MINUS);
        is_lead_zero = !is_sign && r_lead_zero && (i_char == ilwc_pkg::CH_ZERO);
        is_sig       = !is_sign && !is_lead_zero;

        n_st         = r_st;
        n_first      = 1'b0;
        n_lead_zero  = is_sig ? 1'b0 : r_lead_zero;
        n_st.raw_len = ilwc_pkg::sat_inc(r_st.raw_len);
        if (is_sign) begin
            n_st.neg = (i_char == ilwc_pkg::CH_MINUS);
        end
        ref_ch = 8'd0;
        if (is_sig) begin
            n_st.sig_cnt = ilwc_pkg::sat_inc(r_st.sig_cnt);
            for (int b = 0; b < ilwc_pkg::NUM_BOUNDS; b++) begin
                ref_ch = ilwc_pkg::bound_char(3'(b), r_st.sig_cnt);
                if (r_st.sig_cnt < ilwc_pkg::BOUND_LEN[b] &&
                    r_st.status[b] == ilwc_pkg::CMP_UND) begin
                    if (i_char < ref_ch) begin
                        n_st.status[b] = ilwc_pkg::CMP_LESS;
                    end else if (i_char > ref_ch) begin
                        n_st.status[b] = ilwc_pkg::CMP_MORE;
                    end
                end
            end
        end
    end

    assign o_view = n_st;

    // Hold state between characters, clear it after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_first     <= 1'b1;
            r_lead_zero <= 1'b1;
            r_st.neg    <= 1'b0;
            r_st.raw_len <= '0;
            r_st.sig_cnt <= '0;
            for (int b = 0; b < ilwc_pkg::NUM_BOUNDS; b++) begin
                r_st.status[b] <= ilwc_pkg::CMP_UND;
            end
        end else if (i_take) begin
            r_first     <= n_first;
            r_lead_zero <= n_lead_zero;
            r_st        <= n_st;
        end
    end

endmodule

>>> design/ilwc_classify.sv
module ilwc_classify (
    input  ilwc_pkg::t_scan_state i_view,
    output ilwc_pkg::t_class      o_class
);

    logic [ilwc_pkg::CNT_W-1:0] n;
    logic                       more_int;
    logic                       more_ll;

    // Pick the narrowest class from the significant count and bound compares
    always_comb begin
        n        = i_view.sig_cnt;
        more_int = i_view.neg ? (i_view.status[ilwc_pkg::B_INT_NEG] == ilwc_pkg::CMP_MORE)
                              : (i_view.status[ilwc_pkg::B_INT_POS] == ilwc_pkg::CMP_MORE);
        more_ll  = i_view.neg ? (i_view.status[ilwc_pkg::B_LL_NEG] == ilwc_pkg::CMP_MORE)
                              : (i_view.status[ilwc_pkg::B_LL_POS] == ilwc_pkg::CMP_MORE);
        if (i_view.raw_len < ilwc_pkg::CNT_W'(ilwc_pkg::INT_MAX_DIGITS) ||
            n < ilwc_pkg::CNT_W'(ilwc_pkg::INT_MAX_DIGITS)) begin
            o_class = ilwc_pkg::CLS_INT;
        end else if (n == ilwc_pkg::CNT_W'(ilwc_pkg::INT_MAX_DIGITS)) begin
            o_class = more_int ? ilwc_pkg::CLS_LONG : ilwc_pkg::CLS_INT;
        end else if (n < ilwc_pkg::CNT_W'(ilwc_pkg::LL_MAX_DIGITS)) begin
            o_class = ilwc_pkg::CLS_LONG;
        end else if (n == ilwc_pkg::CNT_W'(ilwc_pkg::LL_MAX_DIGITS)) begin
            if (!more_ll) begin
                o_class = ilwc_pkg::CLS_LONG;
            end else begin
                o_class = i_view.neg ? ilwc_pkg::CLS_DEC : ilwc_pkg::CLS_ULONG;
            end
        end else if (i_view.neg ||
                     n > ilwc_pkg::CNT_W'(ilwc_pkg::ULL_MAX_DIGITS)) begin
            o_class = ilwc_pkg::CLS_DEC;
        end else begin
            // unsigned 64-bit length
            o_class = (i_view.status[ilwc_pkg::B_ULL] == ilwc_pkg::CMP_MORE)
                    ? ilwc_pkg::CLS_DEC : ilwc_pkg::CLS_ULONG;
        end
    end

endmodule

>>> design/integer_literal_width_classifier_unit.sv
// Integer literal width classifier: one character item per cycle, unless a
// last item waits on a busy result slot. The class of a literal passes the
// input register, then the result register, once its last item is accepted.
// The per-character state update and the classify logic both sit between
// the input and result registers.
// Reset: synchronous, active low; clears both valid flags and the literal state.
module integer_literal_width_classifier_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_byte
    input  logic       i_s_axis_tlast,   // is_last
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [1:0] literal_class, [7:2] zero
);

    logic                  r_in_valid;
    logic [7:0]            r_in_char;
    logic                  r_in_last;
    logic                  r_out_valid;
    ilwc_pkg::t_class      r_out_class;

    logic                  out_free;
    logic                  advance;
    ilwc_pkg::t_scan_state view;
    ilwc_pkg::t_class      cls;

    // A held item moves on unless it ends a literal and the result slot is busy
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    ilwc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (advance),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_view  (view)
    );

    ilwc_classify u_classify (
        .i_view  (view),
        .o_class (cls)
    );

    // Result register: load on a last item, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_class <= cls;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_class};

endmodule

>>> design/ilwc_checker.sv
module ilwc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // A stalled result holds its value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // With no result pending the input side never stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result slot");

    // A new result follows an accepted last item, through the input and result registers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, 2))
        else $error("result without a last item");

    // Reset leaves no result pending
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind integer_literal_width_classifier_unit ilwc_checker u_ilwc_checker (.*);

>>> verif/integer_literal_width_classifier_unit_tb.sv
module integer_literal_width_classifier_unit_tb;

    import ilwc_pkg::*;

    // Ways to build one random literal
    typedef enum int {
        GEN_NEAR_BOUND,
        GEN_DIGITS,
        GEN_ZEROS,
        GEN_JUNK
    } t_gen_kind;

    // Edits applied to a bound string
    typedef enum int {
        TWEAK_EXACT,
        TWEAK_DIGIT,
        TWEAK_APPEND,
        TWEAK_TRIM
    } t_tweak;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] char_byte
    logic       i_s_axis_tlast;   // is_last
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [1:0] literal_class, [7:2] zero

    // Predicted literal state
    logic       first_pending;
    logic       lit_neg;
    logic [4:0] raw_cnt;
    logic       zeros_run;
    logic [4:0] sig_cnt;
    t_cmp       cmp_state [NUM_BOUNDS];

    t_class     class_queue [$];
    logic [7:0] lit_buf [$];
    int         mismatches;
    int         items_sent;
    logic       steady_flow;

    integer_literal_width_classifier_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound strings, most significant digit first
    function automatic string bound_text(input logic [2:0] b);
        case (b)
            B_INT_POS: return "2147483647";
            B_INT_NEG: return "2147483648";
            B_LL_POS:  return "9223372036854775807";
            B_LL_NEG:  return "9223372036854775808";
            default:   return "18446744073709551615";
        endcase
    endfunction

    function automatic logic [4:0] bump(input logic [4:0] v);
        return (v < 5'(COUNT_CAP)) ? v + 5'd1 : 5'(COUNT_CAP);
    endfunction

    task automatic clear_literal();
        first_pending = 1'b1;
        lit_neg       = 1'b0;
        raw_cnt       = '0;
        zeros_run     = 1'b1;
        sig_cnt       = '0;
        for (int b = 0; b < NUM_BOUNDS; b++) begin
            cmp_state[b] = CMP_UND;
        end
    endtask

    // Append one character to the literal being built
    task automatic add_char(input logic [7:0] ch);
        lit_buf.insert(lit_buf.size(), ch);
    endtask

    // Narrowest class for the literal collected so far
    function automatic t_class literal_class();
        if (raw_cnt < INT_MAX_DIGITS || sig_cnt < INT_MAX_DIGITS) begin
            return CLS_INT;
        end
        if (lit_neg) begin
            if (sig_cnt == INT_MAX_DIGITS) begin
                return (cmp_state[B_INT_NEG] == CMP_MORE) ? CLS_LONG : CLS_INT;
            end
            if (sig_cnt < LL_MAX_DIGITS) begin
                return CLS_LONG;
            end
            if (sig_cnt > LL_MAX_DIGITS) begin
                return CLS_DEC;
            end
            return (cmp_state[B_LL_NEG] == CMP_MORE) ? CLS_DEC : CLS_LONG;
        end
        if (sig_cnt == INT_MAX_DIGITS) begin
            return (cmp_state[B_INT_POS] == CMP_MORE) ? CLS_LONG : CLS_INT;
        end
        if (sig_cnt < LL_MAX_DIGITS) begin
            return CLS_LONG;
        end
        if (sig_cnt == LL_MAX_DIGITS) begin
            return (cmp_state[B_LL_POS] == CMP_MORE) ? CLS_ULONG : CLS_LONG;
        end
        if (sig_cnt > ULL_MAX_DIGITS) begin
            return CLS_DEC;
        end
        return (cmp_state[B_ULL] == CMP_MORE) ? CLS_DEC : CLS_ULONG;
    endfunction

    // Advance the predicted state by one accepted character
    task automatic take_char(input logic [7:0] ch, input logic last_flag);
        logic [7:0] bound_ch;
        string      bt;
        raw_cnt = bump(raw_cnt);
        if (first_pending && (ch == CH_PLUS || ch == CH_MINUS)) begin
            lit_neg = (ch == CH_MINUS);
        end else if (zeros_run && ch == CH_ZERO) begin
            // leading zero, not significant
        end else begin
            zeros_run = 1'b0;
            for (int b = 0; b < NUM_BOUNDS; b++) begin
                bt = bound_text(3'(b));
                if (sig_cnt < bt.len() && cmp_state[b] == CMP_UND) begin
                    bound_ch = bt.getc(sig_cnt);
                    if (ch < bound_ch) begin
                        cmp_state[b] = CMP_LESS;
                    end else if (ch > bound_ch) begin
                        cmp_state[b] = CMP_MORE;
                    end
                end
            end
            sig_cnt = bump(sig_cnt);
        end
        first_pending = 1'b0;
        if (last_flag) begin
            class_queue.insert(class_queue.size(), literal_class());
            clear_literal();
        end
    endtask

    // Drive one item, with random idle cycles ahead of it outside the steady stretch, and wait for its acceptance
    task automatic send_item(input logic [7:0] ch, input logic last_flag);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < 22) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = ch;
        i_s_axis_tlast  = last_flag;
        do @(posedge i_clk); while (!o_s_axis_tready);
        take_char(ch, last_flag);
        items_sent++;
    endtask

    task automatic send_literal();
        for (int i = 0; i < lit_buf.size(); i++) begin
            send_item(lit_buf[i], i == lit_buf.size() - 1);
        end
        lit_buf.delete();
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s.getc(i));
        end
    endtask

    // Optional sign and leading zeros ahead of the digits
    task automatic push_prefix(input logic neg_bias);
        int sign_pick;
        sign_pick = $urandom_range(3);
        if (neg_bias && $urandom_range(4) != 0) begin
            sign_pick = 1;
        end
        if (sign_pick == 0) begin
            add_char(CH_PLUS);
        end else if (sign_pick == 1) begin
            add_char(CH_MINUS);
        end
        if ($urandom_range(9) >= 6) begin
            repeat ($urandom_range(4, 1)) add_char(CH_ZERO);
        end
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    task automatic build_literal();
        t_gen_kind  kind;
        t_tweak     tweak;
        int         pick;
        int         b;
        int         offset;
        int         len;
        string      bt;
        logic [7:0] ch;
        pick = $urandom_range(9);
        kind = (pick < 5) ? GEN_NEAR_BOUND : (pick < 8) ? GEN_DIGITS :
               (pick < 9) ? GEN_ZEROS : GEN_JUNK;
        b    = $urandom_range(NUM_BOUNDS - 1);
        lit_buf.delete();
        push_prefix(kind == GEN_NEAR_BOUND && (b == B_INT_NEG || b == B_LL_NEG));
        offset = lit_buf.size();
        case (kind)
            GEN_NEAR_BOUND: begin
                bt = bound_text(3'(b));
                queue_text(bt);
                tweak = t_tweak'($urandom_range(3));
                case (tweak)
                    TWEAK_DIGIT: begin
                        lit_buf[offset + $urandom_range(bt.len() - 1)] = rand_digit();
                    end
                    TWEAK_APPEND: add_char(rand_digit());
                    TWEAK_TRIM:   void'(lit_buf.pop_back());
                    default: begin
                        // keep the bound as it is
                    end
                endcase
            end
            GEN_DIGITS: begin
                len = $urandom_range(23, 1);
                add_char(8'(CH_ZERO + $urandom_range(9, 1)));
                repeat (len - 1) add_char(rand_digit());
                // stray sign inside the digits
                if (len > 1 && $urandom_range(9) == 0) begin
                    ch = $urandom_range(1) ? CH_PLUS : CH_MINUS;
                    lit_buf[offset + $urandom_range(len - 1, 1)] = ch;
                end
            end
            GEN_ZEROS: begin
                repeat ($urandom_range(15, 1)) add_char(CH_ZERO);
            end
            default: begin
                repeat ($urandom_range(22, 5)) begin
                    ch = ($urandom_range(99) < 20) ? 8'($urandom_range(255)) : rand_digit();
                    add_char(ch);
                end
            end
        endcase
    endtask

    task automatic test_short_specials();
        queue_text("+");        send_literal();
        queue_text("-");        send_literal();
        queue_text("0");        send_literal();
        queue_text("7");        send_literal();
        add_char(8'hFF);        send_literal();
        add_char(8'h00);        send_literal();
        queue_text("-0");       send_literal();
        queue_text("+00");      send_literal();
        queue_text("-123");     send_literal();
        queue_text("99999999"); send_literal();
    endtask

    // Every bound exactly and one above it, with random sign and padding
    task automatic test_bound_edges();
        string bt;
        int    offset;
        for (int b = 0; b < NUM_BOUNDS; b++) begin
            for (int above = 0; above < 2; above++) begin
                push_prefix(b == B_INT_NEG || b == B_LL_NEG);
                offset = lit_buf.size();
                bt = bound_text(3'(b));
                queue_text(bt);
                if (above != 0) begin
                    lit_buf[offset + bt.len() - 1] = lit_buf[offset + bt.len() - 1] + 8'd1;
                end
                send_literal();
            end
        end
    endtask

    task automatic test_random_literals(input int item_target);
        while (items_sent < item_target) begin
            build_literal();
            send_literal();
        end
    endtask

    // Back-to-back items with the result side always ready
    task automatic test_steady_stream();
        int stop_at;
        stop_at     = items_sent + 250;
        steady_flow = 1'b1;
        test_random_literals(stop_at);
        steady_flow = 1'b0;
    endtask

    // Arbitrary bytes and arbitrary literal lengths
    task automatic test_noise();
        repeat (150) begin
            send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] exp_val,
                                   input logic [7:0] act_val);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected %02h, got %02h", $realtime, what, exp_val, act_val);
        end
    endtask

    // Result side: random stalls, except during the steady stretch
    always @(negedge i_clk) begin
        i_m_axis_tready = steady_flow ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // Compare each accepted class with the oldest prediction
    always @(posedge i_clk) begin : check_class
        t_class exp_cls;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (class_queue.size() == 0) begin
                report_mismatch("class with no literal pending", 8'h00, o_m_axis_tdata);
            end else begin
                exp_cls = class_queue.pop_front();
                if (o_m_axis_tdata !== {6'b0, exp_cls}) begin
                    report_mismatch("literal class", {6'b0, exp_cls}, o_m_axis_tdata);
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        steady_flow     = 1'b0;
        mismatches      = 0;
        items_sent      = 0;
        clear_literal();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_specials();
        test_bound_edges();
        test_random_literals(650);
        test_steady_stream();
        test_random_literals(1150);
        test_noise();

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast  = 1'b0;

        // drain outstanding classes, then allow for the pipeline
        while (class_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> integer_literal_width_classifier_unit.f
design/ilwc_pkg.sv
design/ilwc_scan.sv
design/ilwc_classify.sv
design/integer_literal_width_classifier_unit.sv
design/ilwc_checker.sv
verif/integer_literal_width_classifier_unit_tb.sv
